// File: rtl/core/arc4_pkg.sv
// Shared types and constants of the ARC4 keystream engine.
`default_nettype none

package arc4_pkg;

    // Permutation geometry (fixed by the cipher)
    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KLEN_W     = 9;

    // Input command codes
    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [1:0] CMD_CRYPT    = 2'd2;

    // Result kinds
    localparam logic KIND_CRYPT    = 1'b0;
    localparam logic KIND_SCHEDULE = 1'b1;

    // Configuration register indexes and reset values
    localparam logic REG_KEY_LENGTH    = 1'b0;
    localparam logic REG_CIPHER_ENABLE = 1'b1;
    localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 9'd16;
    localparam logic              CIPHER_EN_RST  = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR_J,
        ST_CR_SWAP,
        ST_CR_OUT,
        ST_PASS,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WN,
        ST_KS_WJ,
        ST_KS_DONE
    } t_state;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CR_I,
        DP_PASS_IN,
        DP_KS_START,
        DP_CR_J,
        DP_CR_SWAP,
        DP_CR_OUT,
        DP_PASS,
        DP_KS_RD,
        DP_KS_J,
        DP_KS_WN,
        DP_KS_WJ,
        DP_KS_DONE
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic ks_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/arc4_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module arc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/arc4_ctrl.sv
// Sequencing controller of the ARC4 engine: input acceptance and step order.
`default_nettype none

module arc4_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_cmd,
    input  wire logic             i_cipher_enable,
    input  wire arc4_pkg::t_dp_sts i_sts,
    output logic                  o_in_stall,
    output arc4_pkg::t_dp_cmd     o_cmd
);

    import arc4_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NOP;
        o_cmd.emit = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_LOAD: begin
                            o_cmd.op = DP_LOAD;
                        end
                        CMD_SCHEDULE: begin
                            o_cmd.op = DP_KS_START;
                            n_state  = ST_KS_RD;
                        end
                        CMD_CRYPT: begin
                            if (i_cipher_enable) begin
                                o_cmd.op = DP_CR_I;
                                n_state  = ST_CR_J;
                            end else begin
                                o_cmd.op = DP_PASS_IN;
                                n_state  = ST_PASS;
                            end
                        end
                        default: begin
                            o_cmd.op = DP_NOP;
                        end
                    endcase
                end
            end
            ST_CR_J: begin
                o_cmd.op = DP_CR_J;
                n_state  = ST_CR_SWAP;
            end
            ST_CR_SWAP: begin
                o_cmd.op = DP_CR_SWAP;
                n_state  = ST_CR_OUT;
            end
            ST_CR_OUT: begin
                o_cmd.op   = DP_CR_OUT;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PASS: begin
                o_cmd.op   = DP_PASS;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_KS_RD: begin
                o_cmd.op = DP_KS_RD;
                n_state  = ST_KS_J;
            end
            ST_KS_J: begin
                o_cmd.op = DP_KS_J;
                n_state  = ST_KS_WN;
            end
            ST_KS_WN: begin
                o_cmd.op = DP_KS_WN;
                n_state  = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                o_cmd.op = DP_KS_WJ;
                n_state  = i_sts.ks_last ? ST_KS_DONE : ST_KS_RD;
            end
            ST_KS_DONE: begin
                o_cmd.op   = DP_KS_DONE;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/arc4_dp.sv
// ARC4 datapath: permutation and key memories, indices, swap logic, output register.
`default_nettype none

module arc4_dp #(
    parameter int unsigned KEY_DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire arc4_pkg::t_dp_cmd            i_cmd,
    output arc4_pkg::t_dp_sts                 o_sts,
    input  wire logic [arc4_pkg::KLEN_W-1:0]  i_key_length,
    input  wire logic [arc4_pkg::BYTE_W-1:0]  i_key_index,
    input  wire logic [arc4_pkg::BYTE_W-1:0]  i_data_in,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic      [arc4_pkg::BYTE_W-1:0]  o_data_out,
    output logic                              o_result_kind
);

    import arc4_pkg::*;

    localparam int unsigned     KAW = $clog2(KEY_DEPTH);
    localparam logic [KLEN_W-1:0] KD = KLEN_W'(KEY_DEPTH);

    // Index and scratch registers
    logic [BYTE_W-1:0]     r_i;
    logic [BYTE_W-1:0]     r_j;
    logic [BYTE_W-1:0]     r_a;
    logic [BYTE_W-1:0]     r_b;
    logic [BYTE_W-1:0]     r_t;
    logic [BYTE_W-1:0]     r_data;
    logic [KAW-1:0]        r_kpos;
    logic [KAW-1:0]        n_kpos;
    logic [PERM_DEPTH-1:0] r_vld;
    logic [BYTE_W-1:0]     r_rd_addr;
    logic                  r_rd_vld;
    logic                  r_out_valid;

    // Memory ports
    logic              perm_we;
    logic [BYTE_W-1:0] perm_waddr;
    logic [BYTE_W-1:0] perm_wdata;
    logic [BYTE_W-1:0] perm_raddr;
    logic [BYTE_W-1:0] perm_q;
    logic              key_we;
    logic [BYTE_W-1:0] key_q;

    // Derived values
    logic [BYTE_W-1:0] rd_fix;
    logic [BYTE_W-1:0] i_inc;
    logic [BYTE_W-1:0] cr_j;
    logic [BYTE_W-1:0] cr_t;
    logic [BYTE_W-1:0] ks_j;
    logic [BYTE_W-1:0] ks_byte;
    logic [KLEN_W-1:0] len;
    logic [KLEN_W-1:0] kpos_inc;

    arc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_q)
    );

    arc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_key_index[KAW-1:0]),
        .i_wdata (i_data_in),
        .i_raddr (r_kpos),
        .o_rdata (key_q)
    );

    // Entries not written since the last clear read as identity
    assign rd_fix = r_rd_vld ? perm_q : r_rd_addr;

    assign i_inc = r_i + 8'd1;
    assign cr_j  = r_j + rd_fix;
    assign cr_t  = r_a + rd_fix;
    assign ks_j  = r_j + rd_fix + key_q;

    // Output byte after both swap writes: j was written last
    always_comb begin
        if (r_t == r_j) begin
            ks_byte = r_a;
        end else if (r_t == r_i) begin
            ks_byte = r_b;
        end else begin
            ks_byte = rd_fix;
        end
    end

    // Effective key length, clamped to 1..KEY_DEPTH
    always_comb begin
        if (i_key_length == '0) begin
            len = KLEN_W'(1);
        end else if (i_key_length > KD) begin
            len = KD;
        end else begin
            len = i_key_length;
        end
    end

    // Cyclic key position
    assign kpos_inc = KLEN_W'(r_kpos) + KLEN_W'(1);
    assign n_kpos   = (kpos_inc >= len) ? '0 : kpos_inc[KAW-1:0];

    assign key_we = (i_cmd.op == DP_LOAD) && ({1'b0, i_key_index} < KD);

    // Permutation port selection per step
    always_comb begin
        perm_we    = 1'b0;
        perm_waddr = r_i;
        perm_wdata = rd_fix;
        perm_raddr = i_inc;
        unique case (i_cmd.op)
            DP_CR_J: begin
                perm_raddr = cr_j;
            end
            DP_CR_SWAP: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = rd_fix;
                perm_raddr = cr_t;
            end
            DP_CR_OUT: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_a;
                perm_raddr = r_t;
            end
            DP_KS_RD: begin
                perm_raddr = r_i;
            end
            DP_KS_J: begin
                perm_raddr = ks_j;
            end
            DP_KS_WN: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = rd_fix;
            end
            DP_KS_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_a;
            end
            default: begin
                perm_raddr = i_inc;
            end
        endcase
    end

    // Indices, valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (perm_we) begin
                r_vld[perm_waddr] <= 1'b1;
            end
            unique case (i_cmd.op)
                DP_CR_I: begin
                    r_i <= i_inc;
                end
                DP_CR_J: begin
                    r_j <= cr_j;
                end
                DP_KS_START: begin
                    r_i   <= '0;
                    r_j   <= '0;
                    r_vld <= '0;
                end
                DP_KS_J: begin
                    r_j <= ks_j;
                end
                DP_KS_WJ: begin
                    r_i <= i_inc;
                end
                DP_KS_DONE: begin
                    r_j <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scratch and payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= perm_raddr;
        r_rd_vld  <= r_vld[perm_raddr];
        unique case (i_cmd.op)
            DP_CR_I, DP_PASS_IN: begin
                r_data <= i_data_in;
            end
            DP_CR_J, DP_KS_J: begin
                r_a <= rd_fix;
            end
            DP_CR_SWAP: begin
                r_b <= rd_fix;
                r_t <= cr_t;
            end
            DP_KS_START: begin
                r_kpos <= '0;
            end
            DP_KS_WJ: begin
                r_kpos <= n_kpos;
            end
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            unique case (i_cmd.op)
                DP_CR_OUT: begin
                    o_data_out    <= r_data ^ ks_byte;
                    o_result_kind <= KIND_CRYPT;
                end
                DP_PASS: begin
                    o_data_out    <= r_data;
                    o_result_kind <= KIND_CRYPT;
                end
                default: begin
                    o_data_out    <= '0;
                    o_result_kind <= KIND_SCHEDULE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.ks_last  = (r_i == 8'hff);

endmodule

`default_nettype wire

// File: rtl/core/arc4_stream_cipher.sv
// Crypt with cipher enabled: CR_J, CR_SWAP and CR_OUT follow the input transfer; result registered.
// Crypt with cipher disabled: PASS follows the transfer. Input stalls until the result is registered.
// Key load: taken while idle, no result. Schedule: KS_RD, KS_J, KS_WN and KS_WJ per permutation step
// on the single-read-port permutation memory, then KS_DONE registers the completion.
// Synchronous active-low reset: identity permutation via per-entry valid bits,
// indices zero, key_length 16, cipher_enable 1; key store contents undefined.
`default_nettype none

module arc4_stream_cipher #(
    parameter int unsigned KEY_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_key_index,
    input  wire logic [7:0]  i_data_in,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_data_out,
    output logic             o_result_kind,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import arc4_pkg::*;

    logic [KLEN_W-1:0] r_key_length;
    logic              r_cipher_enable;
    logic              cfg_wr;
    logic              cfg_idx;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length    <= KEY_LENGTH_RST;
            r_cipher_enable <= CIPHER_EN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY_LENGTH:    r_key_length    <= pwdata[KLEN_W-1:0];
                REG_CIPHER_ENABLE: r_cipher_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_KEY_LENGTH:    prdata = {{(32-KLEN_W){1'b0}}, r_key_length};
            REG_CIPHER_ENABLE: prdata = {31'd0, r_cipher_enable};
            default:           prdata = '0;
        endcase
    end

    arc4_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_cmd           (i_cmd),
        .i_cipher_enable (r_cipher_enable),
        .i_sts           (dp_sts),
        .o_in_stall      (o_in_stall),
        .o_cmd           (dp_cmd)
    );

    arc4_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_key_length  (r_key_length),
        .i_key_index   (i_key_index),
        .i_data_in     (i_data_in),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_data_out    (o_data_out),
        .o_result_kind (o_result_kind)
    );

endmodule

`default_nettype wire

// File: rtl/core/arc4_checker.sv
// Port-level checker for the ARC4 engine and its bind to the top level.
`default_nettype none

module arc4_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [1:0] i_cmd,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_data_out,
    input wire logic       o_result_kind
);

    import arc4_pkg::*;

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_data_out) && $stable(o_result_kind))
        else $error("stalled result changed");

    // Schedule completion carries a zero byte
    a_sched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_SCHEDULE) |-> o_data_out == 8'd0)
        else $error("schedule completion with nonzero data");

    // A schedule transfer blocks the input channel in the next cycle
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd == CMD_SCHEDULE) |=> o_in_stall)
        else $error("input taken during key schedule");

endmodule

bind arc4_stream_cipher arc4_checker u_arc4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_data_out    (o_data_out),
    .o_result_kind (o_result_kind)
);

`default_nettype wire
